// ----- design/page_frame_replacement_unit_assert.svh -----
// ----------------------------------------------------------------------------
// page frame replacement unit assertion macros
// wraps concurrent assertions so synthesis sees nothing
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_REPLACEMENT_UNIT_ASSERT_SVH
`define PAGE_FRAME_REPLACEMENT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PFR_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PFR_ASSERT(label, clk, rstn, ante, cons, msg)
`define PFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- design/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// shared widths, register indexes, policy codes and config struct
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    // fixed port widths
    localparam int PAGE_W      = 16;
    localparam int FCNT_W      = 5;
    localparam int CNT_OUT_W   = 5;
    localparam int TOTAL_W     = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 5;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POLICY_MODE = 1'd1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [FCNT_W-1:0] FRAME_COUNT_RST = 5'd4;
    localparam logic              POLICY_RST      = POLICY_LRU;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic [FCNT_W-1:0] frame_count;
        logic              policy_mode;
    } pfr_cfg_t;

endpackage

// ----- design/pfr_front.sv -----
// ----------------------------------------------------------------------------
// pfr_front
// accepts page references, trims them to the page width, queues them
// ----------------------------------------------------------------------------
module pfr_front
    import pfr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PAGE_W-1:0]    s_page,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [PAGE_BITS-1:0] q_page
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [PAGE_BITS-1:0]        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [PAGE_W+PAGE_BITS-1:0] page_ext;
    logic [PAGE_BITS-1:0]        page_in;
    logic                        push, pop;

    // keep only the low page bits, zero-fill when the store is wider
    assign page_ext = {{PAGE_BITS{1'b0}}, s_page};
    assign page_in  = page_ext[PAGE_BITS-1:0];

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_page  = mem_reg[rd_ptr_reg];

    assign push = s_valid && s_ready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= page_in;
        end
    end

endmodule

// ----- design/pfr_back.sv -----
// ----------------------------------------------------------------------------
// pfr_back
// frame list: parallel lookup, then shift/append update and result register
// ----------------------------------------------------------------------------
`include "page_frame_replacement_unit_assert.svh"

module pfr_back
    import pfr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pfr_cfg_t             cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [PAGE_BITS-1:0] q_page,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_fault,
    output logic                 m_evict_valid,
    output logic [PAGE_W-1:0]    m_evicted_page,
    output logic [CNT_OUT_W-1:0] m_resident_count,
    output logic [TOTAL_W-1:0]   m_fault_total
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int OCC_W = $clog2(MAX_FRAMES + 1);
    localparam int LIM_W = (OCC_W > FCNT_W) ? OCC_W : FCNT_W;

    typedef enum logic [1:0] {
        ST_LOOKUP = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [PAGE_BITS-1:0] pages_reg  [MAX_FRAMES];
    logic [PAGE_BITS-1:0] pages_next [MAX_FRAMES];
    logic [PAGE_BITS-1:0] pages_up   [MAX_FRAMES];
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [PAGE_BITS-1:0] pg_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_pos_reg;

    logic                 m_valid_reg;
    logic                 m_fault_reg;
    logic                 m_evict_reg;
    logic [PAGE_W-1:0]    m_evicted_reg;
    logic [CNT_OUT_W-1:0] m_count_reg;
    logic [TOTAL_W-1:0]   m_total_reg;

    logic [MAX_FRAMES-1:0] match;
    logic                  any_hit;
    logic [IDX_W-1:0]      match_pos;

    logic [LIM_W-1:0]      fc_ext, limit_w;
    logic [OCC_W-1:0]      limit;
    logic                  full, evict, append, move, shift_en, wr_en;
    logic [OCC_W-1:0]      shift_pos, wr_idx;
    logic [OCC_W:0]        pos_inc, occ_wide;
    logic                  lookup_fire, upd_fire, out_free;
    logic [PAGE_W+PAGE_BITS-1:0]  ev_ext;
    logic [OCC_W+CNT_OUT_W-1:0]   occ_ext;

    // ---------------- lookup ----------------
    always_comb begin
        match_pos = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            match[k] = (OCC_W'(k) < occ_reg) && (pages_reg[k] == q_page);
        end
        // lowest matching position wins
        for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
            if (match[k]) begin
                match_pos = IDX_W'(k);
            end
        end
    end

    assign any_hit = |match;

    assign q_ready     = (state_reg == ST_LOOKUP);
    assign lookup_fire = q_valid && q_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign upd_fire    = (state_reg == ST_UPDATE) && out_free;

    // ---------------- update decision ----------------
    assign fc_ext  = LIM_W'(cfg.frame_count);
    assign limit_w = (fc_ext == '0) ? LIM_W'(1) :
                     (fc_ext > LIM_W'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES) : fc_ext;
    assign limit   = limit_w[OCC_W-1:0];

    assign occ_wide = {1'b0, occ_reg};
    assign pos_inc  = {{(OCC_W + 1 - IDX_W){1'b0}}, hit_pos_reg} + 1'b1;

    assign full   = (occ_reg >= limit) && (occ_reg != '0);
    assign evict  = !hit_reg && full;
    assign append = !hit_reg && !full && (occ_reg < OCC_W'(MAX_FRAMES));
    assign move   = hit_reg && (cfg.policy_mode == POLICY_LRU) && (pos_inc < occ_wide);

    assign shift_en  = evict || move;
    assign shift_pos = evict ? '0 : OCC_W'(hit_pos_reg);
    assign wr_en     = shift_en || append;
    assign wr_idx    = append ? occ_reg : occ_reg - 1'b1;

    assign occ_next   = append ? occ_reg + 1'b1 : occ_reg;
    assign total_next = (!hit_reg && (total_reg != TOTAL_MAX)) ? total_reg + 1'b1 : total_reg;

    // neighbor one position toward the newest end
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_up
        assign pages_up[g] = pages_reg[(g + 1 < MAX_FRAMES) ? g + 1 : g];
    end

    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            pages_next[k] = pages_reg[k];
            if (shift_en && (OCC_W'(k) >= shift_pos) && ((OCC_W + 1)'(k + 1) < occ_wide)) begin
                pages_next[k] = pages_up[k];
            end
            if (wr_en && (OCC_W'(k) == wr_idx)) begin
                pages_next[k] = pg_reg;
            end
        end
    end

    assign ev_ext  = {{PAGE_W{1'b0}}, pages_reg[0]};
    assign occ_ext = {{CNT_OUT_W{1'b0}}, occ_next};

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOOKUP: begin
                if (lookup_fire) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (upd_fire) begin
                    state_next = ST_LOOKUP;
                end
            end
            default: begin
                state_next = ST_LOOKUP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOOKUP;
            occ_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (upd_fire) begin
                occ_reg   <= occ_next;
                total_reg <= total_next;
            end
            if (upd_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lookup_fire) begin
            pg_reg      <= q_page;
            hit_reg     <= any_hit;
            hit_pos_reg <= match_pos;
        end
        if (upd_fire) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                pages_reg[k] <= pages_next[k];
            end
            m_fault_reg   <= !hit_reg;
            m_evict_reg   <= evict;
            m_evicted_reg <= evict ? ev_ext[PAGE_W-1:0] : '0;
            m_count_reg   <= occ_ext[CNT_OUT_W-1:0];
            m_total_reg   <= total_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_fault          = m_fault_reg;
    assign m_evict_valid    = m_evict_reg;
    assign m_evicted_page   = m_evicted_reg;
    assign m_resident_count = m_count_reg;
    assign m_fault_total    = m_total_reg;

    // ---------------- checks ----------------
    `PFR_ASSERT(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= OCC_W'(MAX_FRAMES), "occupancy beyond frame store")
    `PFR_ASSERT_NEXT(a_occ_no_shrink, aclk, aresetn, upd_fire, occ_reg >= $past(occ_reg), "occupancy dropped")
    `PFR_ASSERT(a_hit_in_list, aclk, aresetn, (state_reg == ST_UPDATE) && hit_reg, OCC_W'(hit_pos_reg) < occ_reg, "hit position outside list")
    `PFR_ASSERT_NEXT(a_result_loaded, aclk, aresetn, upd_fire, m_valid_reg && (m_fault_reg == !$past(hit_reg)), "result not loaded")

endmodule

// ----- design/page_frame_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// page_frame_replacement_unit
// each item passes the queue, then the lookup and update states; its result is registered once the output is free
// the frame list takes no new item until the last one is updated, as it makes a lookup then update pass over the list
// a 2-entry queue takes items while the frame list works and a result waits
// reset: synchronous active low; clears occupancy, fault total and handshakes
// frame_count resets to 4 and policy to LRU; frame contents are not cleared
// ----------------------------------------------------------------------------
module page_frame_replacement_unit
    import pfr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PAGE_W-1:0]     s_page,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_fault,
    output logic                  m_evict_valid,
    output logic [PAGE_W-1:0]     m_evicted_page,
    output logic [CNT_OUT_W-1:0]  m_resident_count,
    output logic [TOTAL_W-1:0]    m_fault_total
);

    logic [FCNT_W-1:0]    frame_count_reg;
    logic                 policy_mode_reg;
    pfr_cfg_t             cfg;
    logic                 q_valid, q_ready;
    logic [PAGE_BITS-1:0] q_page;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= FRAME_COUNT_RST;
            policy_mode_reg <= POLICY_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_COUNT: begin
                    frame_count_reg <= cfg_wdata[FCNT_W-1:0];
                end
                REG_POLICY_MODE: begin
                    policy_mode_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.frame_count = frame_count_reg;
    assign cfg.policy_mode = policy_mode_reg;

    pfr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_page  (s_page),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_page  (q_page)
    );

    pfr_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_page           (q_page),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fault          (m_fault),
        .m_evict_valid    (m_evict_valid),
        .m_evicted_page   (m_evicted_page),
        .m_resident_count (m_resident_count),
        .m_fault_total    (m_fault_total)
    );

endmodule
